// ===== rtl/point_segment_projection_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the point segment projection unit
// Shared concurrent assertion forms, clocked on aclk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef POINT_SEGMENT_PROJECTION_UNIT_ASSERT_SVH
`define POINT_SEGMENT_PROJECTION_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/psp_pkg.sv =====
// ----------------------------------------------------------------------------
// Point segment projection package
// Shared field width, clamp codes and the flag bundle carried along the pipe.
// ----------------------------------------------------------------------------
`default_nettype none

package psp_pkg;

    // Width of one coordinate field on the stream ports.
    localparam int FIELD_BITS = 32;

    // Clamp result codes.
    localparam logic [1:0] CLAMP_NONE  = 2'd0;
    localparam logic [1:0] CLAMP_START = 2'd1;
    localparam logic [1:0] CLAMP_END   = 2'd2;

    // Per-request flags that travel with the data through the divider cells and the back end.
    typedef struct packed {
        logic clamp;
        logic q_zero;
        logic neg_x;
        logic neg_y;
    } psp_flags_t;

endpackage

`default_nettype wire

// ===== rtl/psp_front.sv =====
// ----------------------------------------------------------------------------
// Projection front end
// Registers the request, forms the squared lengths, the split partial
// products, the exact wide numerators and the seed of the divider chain.
// ----------------------------------------------------------------------------
`default_nettype none

module psp_front #(
    parameter int COORD_BITS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [COORD_BITS-1:0]      point_x,
    input  logic signed [COORD_BITS-1:0]      point_y,
    input  logic signed [COORD_BITS-1:0]      start_x,
    input  logic signed [COORD_BITS-1:0]      start_y,
    input  logic signed [COORD_BITS-1:0]      dir_x,
    input  logic signed [COORD_BITS-1:0]      dir_y,
    input  logic                              clamp,
    output logic                              out_valid,
    output psp_pkg::psp_flags_t               out_flags,
    output logic        [2*COORD_BITS-1:0]    out_q,
    output logic        [2*COORD_BITS:0]      out_rem_x,
    output logic        [2*COORD_BITS:0]      out_rem_y,
    output logic        [COORD_BITS+2:0]      out_low_x,
    output logic        [COORD_BITS+2:0]      out_low_y,
    output logic signed [COORD_BITS-1:0]      out_sx,
    output logic signed [COORD_BITS-1:0]      out_sy,
    output logic signed [COORD_BITS-1:0]      out_dx,
    output logic signed [COORD_BITS-1:0]      out_dy
);
    import psp_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int QW    = 2 * CB;
    localparam int PW    = 2 * CB + 2;
    localparam int NW    = 3 * CB + 3;
    localparam int K     = CB + 3;
    localparam int RW    = 2 * CB + 1;
    localparam int NPROD = 6;
    localparam int NSTG  = 6;

    logic [NSTG-1:0]        v_reg;

    // Start, direction and clamp travel along all stages.
    logic signed [CB-1:0]   sxp_reg [NSTG];
    logic signed [CB-1:0]   syp_reg [NSTG];
    logic signed [CB-1:0]   dxp_reg [NSTG];
    logic signed [CB-1:0]   dyp_reg [NSTG];
    logic                   clp_reg [NSTG];

    logic signed [CB-1:0]   px0_reg, py0_reg, px1_reg, py1_reg;
    logic signed [QW-1:0]   dxsq1_reg, dysq1_reg, dxdy1_reg;
    logic signed [CB:0]     ex1_reg, ey1_reg;

    logic        [QW-1:0]   q2_next;
    logic        [QW-1:0]   qp_reg [4];
    logic                   qz_reg [3];

    logic signed [CB:0]     mul_a [NPROD];
    logic        [QW-1:0]   mul_v [NPROD];
    logic signed [PW-1:0]   pp_hi_next [NPROD];
    logic signed [PW-1:0]   pp_lo_next [NPROD];
    logic signed [PW-1:0]   pp_hi_reg [NPROD];
    logic signed [PW-1:0]   pp_lo_reg [NPROD];

    logic signed [NW-1:0]   prod3_reg [NPROD];
    logic signed [NW-1:0]   nx4_reg, ny4_reg;
    logic signed [NW-1:0]   mag_x, mag_y;

    psp_flags_t             flags_reg;
    logic        [RW-1:0]   rem_x_reg, rem_y_reg;
    logic        [K-1:0]    low_x_reg, low_y_reg;

    // Valid bits of the six front stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NSTG-2:0], in_valid};
        end
    end

    // Operands of the twelve partial products.
    always_comb begin
        mul_a[0] = (CB+1)'(px1_reg);    mul_v[0] = dxsq1_reg;
        mul_a[1] = (CB+1)'(sxp_reg[1]); mul_v[1] = dysq1_reg;
        mul_a[2] = ex1_reg;             mul_v[2] = dxdy1_reg;
        mul_a[3] = (CB+1)'(py1_reg);    mul_v[3] = dysq1_reg;
        mul_a[4] = (CB+1)'(syp_reg[1]); mul_v[4] = dxsq1_reg;
        mul_a[5] = ey1_reg;             mul_v[5] = dxdy1_reg;
        for (int i = 0; i < NPROD; i++) begin
            pp_hi_next[i] = PW'(mul_a[i]) * PW'($signed(mul_v[i][QW-1:CB]));
            pp_lo_next[i] = PW'(mul_a[i]) * PW'($signed({1'b0, mul_v[i][CB-1:0]}));
        end
    end

    assign q2_next = dxsq1_reg + dysq1_reg;

    // Magnitudes of the numerators for the divider seed.
    assign mag_x = nx4_reg[NW-1] ? -nx4_reg : nx4_reg;
    assign mag_y = ny4_reg[NW-1] ? -ny4_reg : ny4_reg;

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (en) begin
            // Stage 0: captured request.
            sxp_reg[0] <= start_x;
            syp_reg[0] <= start_y;
            dxp_reg[0] <= dir_x;
            dyp_reg[0] <= dir_y;
            clp_reg[0] <= clamp;
            for (int i = 1; i < NSTG; i++) begin
                sxp_reg[i] <= sxp_reg[i-1];
                syp_reg[i] <= syp_reg[i-1];
                dxp_reg[i] <= dxp_reg[i-1];
                dyp_reg[i] <= dyp_reg[i-1];
                clp_reg[i] <= clp_reg[i-1];
            end
            px0_reg <= point_x;
            py0_reg <= point_y;

            // Stage 1: squares, the dx*dy product and differences.
            px1_reg   <= px0_reg;
            py1_reg   <= py0_reg;
            dxsq1_reg <= QW'(dxp_reg[0]) * QW'(dxp_reg[0]);
            dysq1_reg <= QW'(dyp_reg[0]) * QW'(dyp_reg[0]);
            dxdy1_reg <= QW'(dxp_reg[0]) * QW'(dyp_reg[0]);
            ex1_reg   <= (CB+1)'(syp_reg[0]) - (CB+1)'(py0_reg);
            ey1_reg   <= (CB+1)'(sxp_reg[0]) - (CB+1)'(px0_reg);

            // Stage 2: denominator and partial products.
            qp_reg[0] <= q2_next;
            qz_reg[0] <= (q2_next == '0);
            for (int i = 0; i < NPROD; i++) begin
                pp_hi_reg[i] <= pp_hi_next[i];
                pp_lo_reg[i] <= pp_lo_next[i];
            end

            // Stage 3: full products.
            qp_reg[1] <= qp_reg[0];
            qz_reg[1] <= qz_reg[0];
            for (int i = 0; i < NPROD; i++) begin
                prod3_reg[i] <= (NW'(pp_hi_reg[i]) <<< CB) + NW'(pp_lo_reg[i]);
            end

            // Stage 4: numerators.
            qp_reg[2] <= qp_reg[1];
            qz_reg[2] <= qz_reg[1];
            nx4_reg   <= prod3_reg[0] + prod3_reg[1] - prod3_reg[2];
            ny4_reg   <= prod3_reg[3] + prod3_reg[4] - prod3_reg[5];

            // Stage 5: sign and divider seed.
            qp_reg[3]        <= qp_reg[2];
            flags_reg.clamp  <= clp_reg[4];
            flags_reg.q_zero <= qz_reg[2];
            flags_reg.neg_x  <= nx4_reg[NW-1];
            flags_reg.neg_y  <= ny4_reg[NW-1];
            rem_x_reg        <= {1'b0, mag_x[NW-1:K]};
            rem_y_reg        <= {1'b0, mag_y[NW-1:K]};
            low_x_reg        <= mag_x[K-1:0];
            low_y_reg        <= mag_y[K-1:0];
        end
    end

    assign out_valid = v_reg[NSTG-1];
    assign out_flags = flags_reg;
    assign out_q     = qp_reg[3];
    assign out_rem_x = rem_x_reg;
    assign out_rem_y = rem_y_reg;
    assign out_low_x = low_x_reg;
    assign out_low_y = low_y_reg;
    assign out_sx    = sxp_reg[NSTG-1];
    assign out_sy    = syp_reg[NSTG-1];
    assign out_dx    = dxp_reg[NSTG-1];
    assign out_dy    = dyp_reg[NSTG-1];

endmodule

`default_nettype wire

// ===== rtl/psp_div_cell.sv =====
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step for the x and y numerators against the shared
// denominator; yields one quotient bit per lane and passes everything on.
// ----------------------------------------------------------------------------
`default_nettype none

`include "point_segment_projection_unit_assert.svh"

module psp_div_cell #(
    parameter int COORD_BITS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  psp_pkg::psp_flags_t               in_flags,
    input  logic        [2*COORD_BITS-1:0]    in_q,
    input  logic        [2*COORD_BITS:0]      in_rem_x,
    input  logic        [2*COORD_BITS:0]      in_rem_y,
    input  logic        [COORD_BITS+2:0]      in_low_x,
    input  logic        [COORD_BITS+2:0]      in_low_y,
    input  logic        [COORD_BITS+2:0]      in_quo_x,
    input  logic        [COORD_BITS+2:0]      in_quo_y,
    input  logic signed [COORD_BITS-1:0]      in_sx,
    input  logic signed [COORD_BITS-1:0]      in_sy,
    input  logic signed [COORD_BITS-1:0]      in_dx,
    input  logic signed [COORD_BITS-1:0]      in_dy,
    output logic                              out_valid,
    output psp_pkg::psp_flags_t               out_flags,
    output logic        [2*COORD_BITS-1:0]    out_q,
    output logic        [2*COORD_BITS:0]      out_rem_x,
    output logic        [2*COORD_BITS:0]      out_rem_y,
    output logic        [COORD_BITS+2:0]      out_low_x,
    output logic        [COORD_BITS+2:0]      out_low_y,
    output logic        [COORD_BITS+2:0]      out_quo_x,
    output logic        [COORD_BITS+2:0]      out_quo_y,
    output logic signed [COORD_BITS-1:0]      out_sx,
    output logic signed [COORD_BITS-1:0]      out_sy,
    output logic signed [COORD_BITS-1:0]      out_dx,
    output logic signed [COORD_BITS-1:0]      out_dy
);
    import psp_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int QW = 2 * CB;
    localparam int K  = CB + 3;
    localparam int RW = 2 * CB + 1;

    logic                 valid_reg;
    psp_flags_t           flags_reg;
    logic [QW-1:0]        q_reg;
    logic [RW-1:0]        rem_x_reg, rem_y_reg;
    logic [K-1:0]         low_x_reg, low_y_reg, quo_x_reg, quo_y_reg;
    logic signed [CB-1:0] sx_reg, sy_reg, dx_reg, dy_reg;

    logic [RW-1:0]        q_ext, q_ext_reg;
    logic [RW-1:0]        trial_x, trial_y;
    logic                 ge_x, ge_y;

    // Bring down the next numerator bit and try the subtraction.
    assign q_ext   = {1'b0, in_q};
    assign trial_x = {in_rem_x[RW-2:0], in_low_x[K-1]};
    assign trial_y = {in_rem_y[RW-2:0], in_low_y[K-1]};
    assign ge_x    = (trial_x >= q_ext);
    assign ge_y    = (trial_y >= q_ext);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            flags_reg <= in_flags;
            q_reg     <= in_q;
            rem_x_reg <= ge_x ? trial_x - q_ext : trial_x;
            rem_y_reg <= ge_y ? trial_y - q_ext : trial_y;
            low_x_reg <= {in_low_x[K-2:0], 1'b0};
            low_y_reg <= {in_low_y[K-2:0], 1'b0};
            quo_x_reg <= {in_quo_x[K-2:0], ge_x};
            quo_y_reg <= {in_quo_y[K-2:0], ge_y};
            sx_reg    <= in_sx;
            sy_reg    <= in_sy;
            dx_reg    <= in_dx;
            dy_reg    <= in_dy;
        end
    end

    assign q_ext_reg = {1'b0, q_reg};

    assign out_valid = valid_reg;
    assign out_flags = flags_reg;
    assign out_q     = q_reg;
    assign out_rem_x = rem_x_reg;
    assign out_rem_y = rem_y_reg;
    assign out_low_x = low_x_reg;
    assign out_low_y = low_y_reg;
    assign out_quo_x = quo_x_reg;
    assign out_quo_y = quo_y_reg;
    assign out_sx    = sx_reg;
    assign out_sy    = sy_reg;
    assign out_dx    = dx_reg;
    assign out_dy    = dy_reg;

    // The partial remainder of a live request always stays below the divisor.
    `PSP_ASSERT_NOW(a_rem_below_divisor, valid_reg && !flags_reg.q_zero, (rem_x_reg < q_ext_reg) && (rem_y_reg < q_ext_reg), "divider remainder not below divisor")

endmodule

`default_nettype wire

// ===== rtl/psp_post.sv =====
// ----------------------------------------------------------------------------
// Projection back end
// Applies the quotient sign, tests the foot against the segment ends,
// picks the clamped endpoint and saturates the coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

`include "point_segment_projection_unit_assert.svh"

module psp_post #(
    parameter int COORD_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  psp_pkg::psp_flags_t           in_flags,
    input  logic        [COORD_BITS+2:0]  in_quo_x,
    input  logic        [COORD_BITS+2:0]  in_quo_y,
    input  logic signed [COORD_BITS-1:0]  in_sx,
    input  logic signed [COORD_BITS-1:0]  in_sy,
    input  logic signed [COORD_BITS-1:0]  in_dx,
    input  logic signed [COORD_BITS-1:0]  in_dy,
    output logic                          out_valid,
    output logic signed [COORD_BITS-1:0]  res_x,
    output logic signed [COORD_BITS-1:0]  res_y,
    output logic        [1:0]             res_code
);
    import psp_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int K  = CB + 3;
    localparam int KW = K + 1;
    localparam int EW = KW + 1;

    logic                 valid_reg;
    psp_flags_t           flags_reg;
    logic signed [KW-1:0] fx_reg, fy_reg;
    logic signed [CB:0]   endx_reg, endy_reg;
    logic signed [CB-1:0] sx_reg, sy_reg, dx_reg, dy_reg;

    logic signed [KW-1:0] mag_x, mag_y, fx_next, fy_next;
    logic signed [EW-1:0] e_ax, d_ax;
    logic                 dx_nz, d_pos, d_neg, e_pos, e_neg, before_start, past_end;
    logic signed [KW-1:0] vx, vy;

    // Saturate a wide coordinate to the coordinate range.
    function automatic logic signed [CB-1:0] sat(input logic signed [KW-1:0] v);
        logic signed [CB-1:0] r;
        if ((v[KW-1:CB-1] == '0) || (v[KW-1:CB-1] == '1)) begin
            r = v[CB-1:0];
        end else begin
            r = v[KW-1] ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
        end
        return r;
    endfunction

    // Signed quotient, or the start point for a zero-length line.
    assign mag_x   = $signed({1'b0, in_quo_x});
    assign mag_y   = $signed({1'b0, in_quo_y});
    assign fx_next = in_flags.q_zero ? KW'(in_sx) : (in_flags.neg_x ? -mag_x : mag_x);
    assign fy_next = in_flags.q_zero ? KW'(in_sy) : (in_flags.neg_y ? -mag_y : mag_y);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            flags_reg <= in_flags;
            fx_reg    <= fx_next;
            fy_reg    <= fy_next;
            endx_reg  <= (CB+1)'(in_sx) + (CB+1)'(in_dx);
            endy_reg  <= (CB+1)'(in_sy) + (CB+1)'(in_dy);
            sx_reg    <= in_sx;
            sy_reg    <= in_sy;
            dx_reg    <= in_dx;
            dy_reg    <= in_dy;
        end
    end

    // Clamp test along x, or along y when the direction has no x extent.
    assign dx_nz = (dx_reg != '0);
    assign e_ax  = dx_nz ? (EW'(fx_reg) - EW'(sx_reg)) : (EW'(fy_reg) - EW'(sy_reg));
    assign d_ax  = dx_nz ? EW'(dx_reg) : EW'(dy_reg);
    assign d_neg = d_ax[EW-1];
    assign d_pos = !d_ax[EW-1] && (d_ax != '0);
    assign e_neg = e_ax[EW-1];
    assign e_pos = !e_ax[EW-1] && (e_ax != '0);

    assign before_start = (d_pos && e_neg) || (d_neg && e_pos);
    assign past_end     = (d_pos && (e_ax > d_ax)) || (d_neg && (e_ax < d_ax));

    always_comb begin
        if (!flags_reg.clamp) begin
            res_code = CLAMP_NONE;
        end else if (before_start) begin
            res_code = CLAMP_START;
        end else if (past_end) begin
            res_code = CLAMP_END;
        end else begin
            res_code = CLAMP_NONE;
        end
    end

    // Pick the reported point.
    always_comb begin
        case (res_code)
            CLAMP_START: begin
                vx = KW'(sx_reg);
                vy = KW'(sy_reg);
            end
            CLAMP_END: begin
                vx = KW'(endx_reg);
                vy = KW'(endy_reg);
            end
            default: begin
                vx = fx_reg;
                vy = fy_reg;
            end
        endcase
    end

    assign res_x     = sat(vx);
    assign res_y     = sat(vy);
    assign out_valid = valid_reg;

    // Only a clamping request on a real segment can report a clamp.
    `PSP_ASSERT_NOW(a_clamp_only_when_asked, valid_reg && (!flags_reg.clamp || flags_reg.q_zero), res_code == CLAMP_NONE, "clamp code without clamping")

endmodule

`default_nettype wire

// ===== rtl/point_segment_projection_unit.sv =====
// Path: a request passes the front stages, the divider cells, the back-end
// register and the output register before its result shows in m_tvalid.
// Throughput: one request per cycle unless a finished result waits on a full
// output; the divider is a row of COORD_BITS+3 cells, one quotient bit each,
// so it can start a new division every cycle that the pipe moves.
// Reset: aresetn clears the stage and output valid flags; data registers are not reset.
// ----------------------------------------------------------------------------
// Point segment projection unit
// Projects a point onto a line or segment in signed 16.16 fixed point through
// a multiplier front end, a chain of divider cells and a clamp back end.
// ----------------------------------------------------------------------------
`default_nettype none

`include "point_segment_projection_unit_assert.svh"

module point_segment_projection_unit #(
    parameter int COORD_BITS = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // point_x, point_y, start_x, start_y, dir_x, dir_y
    input  logic [6*psp_pkg::FIELD_BITS-1:0]   s_tdata,
    // clamp_to_segment
    input  logic [0:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // proj_x, proj_y
    output logic [2*psp_pkg::FIELD_BITS-1:0]   m_tdata,
    // clamp_code
    output logic [1:0]                         m_tuser
);
    import psp_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int QW = 2 * CB;
    localparam int K  = CB + 3;
    localparam int RW = 2 * CB + 1;
    localparam int FB = FIELD_BITS;

    logic                 en, out_load;

    logic                 c_valid [K+1];
    psp_flags_t           c_flags [K+1];
    logic [QW-1:0]        c_q     [K+1];
    logic [RW-1:0]        c_rem_x [K+1];
    logic [RW-1:0]        c_rem_y [K+1];
    logic [K-1:0]         c_low_x [K+1];
    logic [K-1:0]         c_low_y [K+1];
    logic [K-1:0]         c_quo_x [K+1];
    logic [K-1:0]         c_quo_y [K+1];
    logic signed [CB-1:0] c_sx    [K+1];
    logic signed [CB-1:0] c_sy    [K+1];
    logic signed [CB-1:0] c_dx    [K+1];
    logic signed [CB-1:0] c_dy    [K+1];

    logic                 post_valid;
    logic signed [CB-1:0] res_x, res_y;
    logic [1:0]           res_code;

    logic                 m_valid_reg;
    logic [2*FB-1:0]      m_data_reg;
    logic [1:0]           m_user_reg;

    // The pipe moves unless a finished result is blocked by a full output.
    assign out_load = !m_valid_reg || m_tready;
    assign en       = out_load || !post_valid;
    assign s_tready = en;

    psp_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .point_x   ($signed(s_tdata[0*FB +: CB])),
        .point_y   ($signed(s_tdata[1*FB +: CB])),
        .start_x   ($signed(s_tdata[2*FB +: CB])),
        .start_y   ($signed(s_tdata[3*FB +: CB])),
        .dir_x     ($signed(s_tdata[4*FB +: CB])),
        .dir_y     ($signed(s_tdata[5*FB +: CB])),
        .clamp     (s_tuser[0]),
        .out_valid (c_valid[0]),
        .out_flags (c_flags[0]),
        .out_q     (c_q[0]),
        .out_rem_x (c_rem_x[0]),
        .out_rem_y (c_rem_y[0]),
        .out_low_x (c_low_x[0]),
        .out_low_y (c_low_y[0]),
        .out_sx    (c_sx[0]),
        .out_sy    (c_sy[0]),
        .out_dx    (c_dx[0]),
        .out_dy    (c_dy[0])
    );

    assign c_quo_x[0] = '0;
    assign c_quo_y[0] = '0;

    // Divider chain: one quotient bit per cell.
    for (genvar i = 0; i < K; i++) begin : g_cell
        psp_div_cell #(
            .COORD_BITS (COORD_BITS)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (c_valid[i]),
            .in_flags  (c_flags[i]),
            .in_q      (c_q[i]),
            .in_rem_x  (c_rem_x[i]),
            .in_rem_y  (c_rem_y[i]),
            .in_low_x  (c_low_x[i]),
            .in_low_y  (c_low_y[i]),
            .in_quo_x  (c_quo_x[i]),
            .in_quo_y  (c_quo_y[i]),
            .in_sx     (c_sx[i]),
            .in_sy     (c_sy[i]),
            .in_dx     (c_dx[i]),
            .in_dy     (c_dy[i]),
            .out_valid (c_valid[i+1]),
            .out_flags (c_flags[i+1]),
            .out_q     (c_q[i+1]),
            .out_rem_x (c_rem_x[i+1]),
            .out_rem_y (c_rem_y[i+1]),
            .out_low_x (c_low_x[i+1]),
            .out_low_y (c_low_y[i+1]),
            .out_quo_x (c_quo_x[i+1]),
            .out_quo_y (c_quo_y[i+1]),
            .out_sx    (c_sx[i+1]),
            .out_sy    (c_sy[i+1]),
            .out_dx    (c_dx[i+1]),
            .out_dy    (c_dy[i+1])
        );
    end

    psp_post #(
        .COORD_BITS (COORD_BITS)
    ) u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (c_valid[K]),
        .in_flags  (c_flags[K]),
        .in_quo_x  (c_quo_x[K]),
        .in_quo_y  (c_quo_y[K]),
        .in_sx     (c_sx[K]),
        .in_sy     (c_sy[K]),
        .in_dx     (c_dx[K]),
        .in_dy     (c_dy[K]),
        .out_valid (post_valid),
        .res_x     (res_x),
        .res_y     (res_y),
        .res_code  (res_code)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= post_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= {FB'(res_y), FB'(res_x)};
            m_user_reg <= res_code;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // Input is refused only while a finished result waits on a full output.
    `PSP_ASSERT_NOW(a_stall_only_when_full, !s_tready, m_tvalid && !m_tready && post_valid, "input stalled without a blocked result")

    // A finished result that moves on lands in the output register.
    `PSP_ASSERT_NEXT(a_result_reaches_output, post_valid && s_tready, m_tvalid, "finished result lost before output")

endmodule

`default_nettype wire

// ===== tb/point_segment_projection_checker.sv =====
// ----------------------------------------------------------------------------
// Point segment projection checker
// Watches both stream channels of the projection unit, computes the expected
// foot of the perpendicular for every accepted request and compares each
// accepted result against the oldest outstanding expectation.
// ----------------------------------------------------------------------------
`default_nettype none

module point_segment_projection_checker (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    input  wire logic          s_tready,
    // point_x, point_y, start_x, start_y, dir_x, dir_y
    input  wire logic [191:0]  s_tdata,
    // clamp_to_segment
    input  wire logic [0:0]    s_tuser,
    input  wire logic          m_tvalid,
    input  wire logic          m_tready,
    // proj_x, proj_y
    input  wire logic [63:0]   m_tdata,
    // clamp_code
    input  wire logic [1:0]    m_tuser,
    output int                 mismatch_count,
    output int                 feet_pending,
    output int                 requests_seen,
    output int                 feet_seen,
    output int                 start_clamps,
    output int                 end_clamps
);
    import psp_pkg::*;

    typedef struct packed {
        logic [31:0] proj_x;
        logic [31:0] proj_y;
        logic [1:0]  clamp_code;
    } foot_t;

    foot_t expected_feet[$];

    // Saturate a wide value to a signed range of the given number of bits.
    function automatic logic signed [127:0] saturate(logic signed [127:0] v, int bits);
        logic signed [127:0] hi;
        logic signed [127:0] lo;
        hi = (128'sd1 <<< (bits - 1)) - 128'sd1;
        lo = -hi - 128'sd1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // Foot of the perpendicular, exact numerators over dx^2+dy^2, with clamping.
    function automatic foot_t project_point(logic [191:0] data, logic clamp);
        logic signed [127:0] px, py, sx, sy, dx, dy, q, nx, ny, fx, fy, e, d;
        foot_t f;
        px = $signed(data[31:0]);
        py = $signed(data[63:32]);
        sx = $signed(data[95:64]);
        sy = $signed(data[127:96]);
        dx = $signed(data[159:128]);
        dy = $signed(data[191:160]);
        q = dx * dx + dy * dy;
        fx = sx;
        fy = sy;
        f.clamp_code = CLAMP_NONE;
        if (q != 0) begin
            nx = px * dx * dx + sx * dy * dy - (sy - py) * dx * dy;
            ny = py * dy * dy + sy * dx * dx - (sx - px) * dx * dy;
            fx = saturate(nx / q, 64);
            fy = saturate(ny / q, 64);
        end
        if (clamp) begin
            e = (dx != 0) ? fx - sx : fy - sy;
            d = (dx != 0) ? dx : dy;
            if ((d > 0 && e < 0) || (d < 0 && e > 0)) begin
                fx = sx;
                fy = sy;
                f.clamp_code = CLAMP_START;
            end else if ((d > 0 && e > d) || (d < 0 && e < d)) begin
                fx = sx + dx;
                fy = sy + dy;
                f.clamp_code = CLAMP_END;
            end
        end
        fx = saturate(fx, 32);
        fy = saturate(fy, 32);
        f.proj_x = fx[31:0];
        f.proj_y = fy[31:0];
        return f;
    endfunction

    assign feet_pending = expected_feet.size();

    // Record expectations on accepted requests, compare accepted results.
    always @(posedge aclk) begin
        foot_t want;
        foot_t got;
        if (!aresetn) begin
            mismatch_count <= 0;
            requests_seen  <= 0;
            feet_seen      <= 0;
            start_clamps   <= 0;
            end_clamps     <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_feet.push_back(project_point(s_tdata, s_tuser[0]));
                requests_seen <= requests_seen + 1;
            end
            if (m_tvalid && m_tready) begin
                got.proj_x     = m_tdata[31:0];
                got.proj_y     = m_tdata[63:32];
                got.clamp_code = m_tuser;
                feet_seen <= feet_seen + 1;
                if (got.clamp_code == CLAMP_START) start_clamps <= start_clamps + 1;
                if (got.clamp_code == CLAMP_END) end_clamps <= end_clamps + 1;
                if (expected_feet.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("Unexpected result: x=%h y=%h code=%0d",
                                 got.proj_x, got.proj_y, got.clamp_code);
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    want = expected_feet.pop_front();
                    if (want != got) begin
                        if (mismatch_count < 10)
                            $display("Mismatch: expected x=%h y=%h code=%0d, got x=%h y=%h code=%0d",
                                     want.proj_x, want.proj_y, want.clamp_code,
                                     got.proj_x, got.proj_y, got.clamp_code);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== tb/point_segment_projection_unit_test.sv =====
// ----------------------------------------------------------------------------
// Point segment projection unit testbench
// Drives directed and random projection requests with bursty input and a
// stalling output, and reports the verdict from the checker's mismatch count and pending results.
// ----------------------------------------------------------------------------
`default_nettype none

module point_segment_projection_unit_test;
    import psp_pkg::*;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [191:0]  s_tdata = '0;
    logic [0:0]    s_tuser = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [63:0]   m_tdata;
    logic [1:0]    m_tuser;

    int mismatch_count, feet_pending, requests_seen, feet_seen;
    int start_clamps, end_clamps;
    int cycle_count = 0;

    always #2 aclk = ~aclk;

    point_segment_projection_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    point_segment_projection_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .mismatch_count(mismatch_count), .feet_pending(feet_pending),
        .requests_seen(requests_seen), .feet_seen(feet_seen),
        .start_clamps(start_clamps), .end_clamps(end_clamps)
    );

    // Offer one request and hold it until the unit takes it.
    task automatic send_request(logic [31:0] px, logic [31:0] py, logic [31:0] sx,
                                logic [31:0] sy, logic [31:0] dx, logic [31:0] dy,
                                logic clamp);
        s_tvalid <= 1'b1;
        s_tdata  <= {dy, dx, sy, sx, py, px};
        s_tuser  <= clamp;
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
    endtask

    // Random coordinate of a chosen scale: tiny, moderate, full range or extreme.
    function automatic logic [31:0] random_coord(int scale);
        case (scale)
            0: return $urandom_range(0, 64) - 32;
            1: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
            2: return $urandom();
            default: return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        endcase
    endfunction

    // Receiver: a cycling stall pattern, with one long hold-off to fill the pipe.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= 1500 && cycle_count < 1800)
            m_tready <= 1'b0;
        else if (cycle_count[9:8] == 2'd0)
            m_tready <= 1'b1;
        else if (cycle_count[9:8] == 2'd1)
            m_tready <= ($urandom_range(0, 3) != 0);
        else
            m_tready <= ($urandom_range(0, 1) != 0);
    end

    // Run limit.
    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    // Stimulus and verdict.
    initial begin
        int burst;
        int scale;
        int shape;
        logic [31:0] dx, dy;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes, zero-length line, vertical line, each clamp outcome.
        send_request(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 32'h0001_0000, 0, 1'b0);
        send_request(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 32'h0001_0000, 1'b0);
        send_request(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 0, 0, 1'b1);
        send_request(32'h0001_0000, 32'h0002_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 1'b0);
        send_request(32'hFFFF_0000, 32'h0005_0000, 0, 0, 32'h0002_0000, 0, 1'b1);
        send_request(32'h0003_0000, 32'h0005_0000, 0, 0, 32'h0002_0000, 0, 1'b1);
        send_request(32'h0001_0000, 32'h0005_0000, 0, 0, 32'h0002_0000, 0, 1'b1);
        send_request(32'h0002_0000, 32'h0005_0000, 0, 0, 32'h0002_0000, 0, 1'b1);
        send_request(0, 32'h0005_0000, 0, 0, 32'h0002_0000, 0, 1'b1);
        send_request(32'h0005_0000, 32'hFFFF_0000, 0, 0, 0, 32'h0002_0000, 1'b1);
        send_request(32'h0005_0000, 32'h0003_0000, 0, 0, 0, 32'h0002_0000, 1'b1);
        send_request(32'h0005_0000, 32'h0003_0000, 0, 0, 0, 32'hFFFE_0000, 1'b1);
        send_request(32'h0005_0000, 32'hFFFD_0000, 0, 0, 0, 32'hFFFE_0000, 1'b1);
        send_request(32'h0004_0000, 32'h0001_0000, 0, 0, 32'h0001_0000, 32'h0001_0000, 1'b1);
        send_request(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'h8000_0000, 1'b0);
        send_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                     32'h0000_0001, 32'h7FFF_FFFF, 1'b0);
        send_request(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        send_request(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h8000_0000, 32'h0000_0001, 1'b1);
        send_request(32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0000_0001,
                     32'hFFFF_FFFF, 1'b1);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);

        // Random: bursts of requests separated by idle gaps.
        for (int n = 0; n < 1100; ) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && n < 1100; k++, n++) begin
                scale = $urandom_range(0, 9);
                scale = (scale < 4) ? 0 : (scale < 7) ? 1 : (scale < 9) ? 2 : 3;
                shape = $urandom_range(0, 15);
                dx = random_coord(scale);
                dy = random_coord(scale);
                if (shape == 0) dx = 0;
                if (shape == 1) dy = 0;
                if (shape == 2) begin
                    dx = 0;
                    dy = 0;
                end
                send_request(random_coord(scale), random_coord(scale), random_coord(scale),
                             random_coord(scale), dx, dy, $urandom_range(0, 3) != 0);
            end
            if (n < 900 && $urandom_range(0, 2) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b0;

        // Drain the pipe.
        while (feet_pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);

        $display("Covered %0d projection requests and %0d results.", requests_seen, feet_seen);
        $display("Clamped to start %0d times, to end %0d times.", start_clamps, end_clamps);
        if (mismatch_count == 0 && feet_pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
